// ===== rtl/tlge_pkg.sv =====
// Shared types, constants and helper functions for the toroidal life engine.
// Depends on nothing; the controller, datapath, top level and checker import it.
package tlge_pkg;

    // grid size limits
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 128;
    localparam int RIDX_W   = $clog2(MAX_ROWS);
    localparam int CIDX_W   = $clog2(MAX_COLS);

    // field and register widths
    localparam int OP_W        = 2;
    localparam int ROW_W       = 6;
    localparam int COL_W       = 7;
    localparam int ROWS_CFG_W  = 7;
    localparam int COLS_CFG_W  = 8;
    localparam int MASK_W      = 9;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int NBR_CNT_W   = 4;

    // register reset values (B3/S23 on a 54 x 96 field)
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET    = 7'd54;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET    = 8'd96;
    localparam logic [MASK_W-1:0]     BIRTH_RESET   = 9'b0_0000_1000;
    localparam logic [MASK_W-1:0]     SURVIVE_RESET = 9'b0_0000_1100;

    // request kinds
    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ADVANCE = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS    = 2'd0,
        CFG_COLS    = 2'd1,
        CFG_BIRTH   = 2'd2,
        CFG_SURVIVE = 2'd3
    } cfg_idx_t;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_FETCH,
        ST_USE,
        ST_ADV_LAST,
        ST_ADV_FIRST,
        ST_ADV_SECOND,
        ST_ADV_ROW,
        ST_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_write;   // write a zero row at the counter, step counter
        logic req_load;    // capture the incoming request
        logic fetch;       // read the requested row
        logic use_cell;    // read-modify-write or capture the addressed cell
        logic adv_last;    // read the last used row
        logic adv_first;   // read row 0, hold last row as the row above
        logic adv_second;  // read row 1, hold row 0, clear counter
        logic adv_row;     // produce one new row, step counter
        logic out_load;    // move the result into the output register
    } ctl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_region;
        logic            row_last;
        logic            clr_last;
        logic            slot_free;
    } dp_status_t;

    // last used row index from the row count register
    function automatic logic [RIDX_W-1:0] rows_last(input logic [ROWS_CFG_W-1:0] v);
        logic [RIDX_W-1:0] r;
        if (v < ROWS_CFG_W'(3))
            r = RIDX_W'(2);
        else if (int'(v) > MAX_ROWS)
            r = RIDX_W'(MAX_ROWS - 1);
        else
            r = RIDX_W'(v - 1'b1);
        return r;
    endfunction

    // last used column index from the column count register
    function automatic logic [CIDX_W-1:0] cols_last(input logic [COLS_CFG_W-1:0] v);
        logic [CIDX_W-1:0] r;
        if (v < COLS_CFG_W'(3))
            r = CIDX_W'(2);
        else if (int'(v) > MAX_COLS)
            r = CIDX_W'(MAX_COLS - 1);
        else
            r = CIDX_W'(v - 1'b1);
        return r;
    endfunction

    // next state of one cell from its eight neighbors
    function automatic logic life_next(
        input logic [7:0]        nbrs,
        input logic              alive,
        input logic [MASK_W-1:0] birth,
        input logic [MASK_W-1:0] survive
    );
        logic [NBR_CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
            n = n + NBR_CNT_W'(nbrs[i]);
        return alive ? survive[n] : birth[n];
    endfunction

endpackage

// ===== rtl/tlge_ram.sv =====
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module tlge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tlge_ctrl.sv =====
// Sequencer for the life engine: clearing pass, request decode, row sweep.
// Depends on tlge_pkg.
module tlge_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tlge_pkg::dp_status_t status,
    output tlge_pkg::ctl_cmd_t   cmd
);
    import tlge_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                unique case (status.op)
                    OP_WRITE, OP_READ:
                        state_next = status.in_region ? ST_FETCH : ST_DONE;
                    OP_ADVANCE:
                        state_next = ST_ADV_LAST;
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_FETCH:      state_next = ST_USE;
            ST_USE:        state_next = ST_DONE;
            ST_ADV_LAST:   state_next = ST_ADV_FIRST;
            ST_ADV_FIRST:  state_next = ST_ADV_SECOND;
            ST_ADV_SECOND: state_next = ST_ADV_ROW;
            ST_ADV_ROW:
            begin
                if (status.row_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.slot_free)
                    state_next = ST_IDLE;
            end
            default:       state_next = ST_CLEAR;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:      cmd.clr_write = 1'b1;
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.req_load = in_valid;
            end
            ST_DECODE:     cmd = '0;
            ST_FETCH:      cmd.fetch = 1'b1;
            ST_USE:        cmd.use_cell = 1'b1;
            ST_ADV_LAST:   cmd.adv_last = 1'b1;
            ST_ADV_FIRST:  cmd.adv_first = 1'b1;
            ST_ADV_SECOND: cmd.adv_second = 1'b1;
            ST_ADV_ROW:    cmd.adv_row = 1'b1;
            ST_DONE:       cmd.out_load = status.slot_free;
            default:       cmd = '0;
        endcase
    end

endmodule

// ===== rtl/tlge_datapath.sv =====
// Datapath of the life engine: registers, row-wide grid memory, row window,
// one lane per column for the neighbor rule, and the output register.
// Depends on tlge_pkg and tlge_ram.
module tlge_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tlge_pkg::ctl_cmd_t              cmd,
    output tlge_pkg::dp_status_t            status,
    input  logic                            cfg_write,
    input  logic [tlge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlge_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [tlge_pkg::OP_W-1:0]       op,
    input  logic [tlge_pkg::ROW_W-1:0]      row,
    input  logic [tlge_pkg::COL_W-1:0]      col,
    input  logic                            cell_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tlge_pkg::OP_W-1:0]       kind,
    output logic                            cell_out
);
    import tlge_pkg::*;

    // configuration registers
    logic [ROWS_CFG_W-1:0] rows_used_reg;
    logic [COLS_CFG_W-1:0] cols_used_reg;
    logic [MASK_W-1:0]     birth_mask_reg;
    logic [MASK_W-1:0]     survive_mask_reg;

    // request registers
    logic [OP_W-1:0]  op_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             val_reg;
    logic             cell_reg;

    // row window and counter
    logic [RIDX_W-1:0]   cnt_reg;
    logic [MAX_COLS-1:0] above_reg;
    logic [MAX_COLS-1:0] cur_reg;
    logic [MAX_COLS-1:0] first_reg;

    // output register
    logic            out_valid_reg;
    logic [OP_W-1:0] kind_reg;
    logic            cell_out_reg;

    logic [RIDX_W-1:0]   nr_m1;
    logic [CIDX_W-1:0]   nc_m1;
    logic [RIDX_W-1:0]   req_row;
    logic [CIDX_W-1:0]   req_col;
    logic                ram_we;
    logic [RIDX_W-1:0]   ram_waddr;
    logic [MAX_COLS-1:0] ram_wdata;
    logic [RIDX_W-1:0]   ram_raddr;
    logic [MAX_COLS-1:0] ram_rdata;
    logic [MAX_COLS-1:0] below;
    logic [MAX_COLS-1:0] new_row;
    logic [MAX_COLS-1:0] patched_row;

    assign nr_m1   = rows_last(rows_used_reg);
    assign nc_m1   = cols_last(cols_used_reg);
    assign req_row = RIDX_W'(row_reg);
    assign req_col = CIDX_W'(col_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg    <= ROWS_RESET;
            cols_used_reg    <= COLS_RESET;
            birth_mask_reg   <= BIRTH_RESET;
            survive_mask_reg <= SURVIVE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROWS:    rows_used_reg    <= cfg_data[ROWS_CFG_W-1:0];
                CFG_COLS:    cols_used_reg    <= cfg_data[COLS_CFG_W-1:0];
                CFG_BIRTH:   birth_mask_reg   <= cfg_data[MASK_W-1:0];
                CFG_SURVIVE: survive_mask_reg <= cfg_data[MASK_W-1:0];
            endcase
        end
    end

    // request capture and cell result
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            op_reg   <= op;
            row_reg  <= row;
            col_reg  <= col;
            val_reg  <= cell_in;
            cell_reg <= 1'b0;
        end
        else if (cmd.use_cell && op_reg == OP_READ)
        begin
            cell_reg <= ram_rdata[req_col];
        end
    end

    // row counter shared by the clearing pass and the generation sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.adv_second)
            cnt_reg <= '0;
        else if (cmd.clr_write || cmd.adv_row)
            cnt_reg <= cnt_reg + 1'b1;
    end

    // three-row window; the old row 0 is kept for the last row's wrap
    assign below = (cnt_reg == nr_m1) ? first_reg : ram_rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.adv_first)
            above_reg <= ram_rdata;
        if (cmd.adv_second)
        begin
            cur_reg   <= ram_rdata;
            first_reg <= ram_rdata;
        end
        if (cmd.adv_row)
        begin
            above_reg <= cur_reg;
            cur_reg   <= below;
        end
    end

    // one lane per column, wrapping at the last used column
    always_comb
    begin
        logic [CIDX_W-1:0] cl;
        logic [CIDX_W-1:0] cr;
        logic [7:0]        nb;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            cl = (c == 0) ? nc_m1 : CIDX_W'(c - 1);
            cr = (CIDX_W'(c) == nc_m1) ? '0 : CIDX_W'(c + 1);
            nb = {above_reg[cl], above_reg[c], above_reg[cr],
                  cur_reg[cl], cur_reg[cr],
                  below[cl], below[c], below[cr]};
            if (CIDX_W'(c) <= nc_m1)
                new_row[c] = life_next(nb, cur_reg[c], birth_mask_reg, survive_mask_reg);
            else
                new_row[c] = cur_reg[c];
        end
    end

    // single cell update inside a fetched row
    always_comb
    begin
        patched_row          = ram_rdata;
        patched_row[req_col] = val_reg;
    end

    // memory port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = new_row;
        priority if (cmd.clr_write)
        begin
            ram_we    = 1'b1;
            ram_wdata = '0;
        end
        else if (cmd.use_cell && op_reg == OP_WRITE)
        begin
            ram_we    = 1'b1;
            ram_waddr = req_row;
            ram_wdata = patched_row;
        end
        else if (cmd.adv_row)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        priority if (cmd.fetch)
            ram_raddr = req_row;
        else if (cmd.adv_last)
            ram_raddr = nr_m1;
        else if (cmd.adv_first)
            ram_raddr = '0;
        else if (cmd.adv_second)
            ram_raddr = RIDX_W'(1);
        else
            ram_raddr = cnt_reg + RIDX_W'(2);
    end

    tlge_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            kind_reg     <= op_reg;
            cell_out_reg <= cell_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign cell_out  = cell_out_reg;

    // status to the controller
    assign status.op        = op_reg;
    assign status.in_region = (row_reg <= nr_m1) && (col_reg <= nc_m1);
    assign status.row_last  = (cnt_reg == nr_m1);
    assign status.clr_last  = (cnt_reg == RIDX_W'(MAX_ROWS - 1));
    assign status.slot_free = !out_valid_reg || !out_stall;

endmodule

// ===== rtl/toroidal_life_generation_engine.sv =====
// Top level of the toroidal life engine: controller plus datapath.
// Depends on tlge_pkg, tlge_ctrl, tlge_datapath (and through it tlge_ram).
//
// A 64 x 128 one-bit grid, stored one row per memory word, that wraps at the
// configured row and column counts. After reset a clearing pass writes every
// row to zero, one row a cycle, and no request is taken during it; the user
// is to make configuration writes only while the block is idle, which the
// block itself does not enforce. Cell write and cell read requests pass
// through decode, row fetch, row update or bit pick, and result; one that
// falls outside the used region, and a request of unknown kind, passes
// through decode and result only. An advance request sweeps the used rows
// once, one row per cycle, with all columns of a row computed side by side;
// the single read port of the grid memory limits the sweep to one row per
// cycle. One request is in work at a time; the next is taken as soon as the
// current result sits in the output register, even if it is not yet taken.
module toroidal_life_generation_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [tlge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlge_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tlge_pkg::OP_W-1:0]       op,
    input  logic [tlge_pkg::ROW_W-1:0]      row,
    input  logic [tlge_pkg::COL_W-1:0]      col,
    input  logic                            cell_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tlge_pkg::OP_W-1:0]       kind,
    output logic                            cell_out
);
    import tlge_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    tlge_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tlge_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (op),
        .row       (row),
        .col       (col),
        .cell_in   (cell_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .cell_out  (cell_out)
    );

endmodule

// ===== rtl/tlge_checker.sv =====
// Port-level checks for the life engine and the bind that attaches them.
// Depends on tlge_pkg and toroidal_life_generation_engine.
module tlge_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [tlge_pkg::OP_W-1:0] kind,
    input logic                      cell_out
);
    import tlge_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(cell_out))
    else $error("stalled result changed");

    // only a read answer carries a live cell
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cell_out |-> kind == OP_READ)
    else $error("cell_out set on a non-read result");

    // one request at a time: stall right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in work");

    // no result shows up in the cycle right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind toroidal_life_generation_engine tlge_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .cell_out  (cell_out)
);
